### sv/ctss_pkg.sv
// Shared constants and codes for the call trace shadow stack.
package ctss_pkg;

   localparam int WordWidth  = 64;
   localparam int StackDepth = 32;
   localparam int MaxResults = 32;

   localparam logic OpEnter = 1'b0;
   localparam logic OpExit  = 1'b1;

   localparam logic [1:0] StatusOk    = 2'd0;
   localparam logic [1:0] StatusFull  = 2'd1;
   localparam logic [1:0] StatusEmpty = 2'd2;

endpackage

### sv/call_trace_shadow_stack_unit.sv
// Shadow return stack for a call tracer: frame memory, pop sequencer and record output.
// Each event finishes before the next request is accepted; a full output register stalls it.
// An exit event pops P frames, one per cycle while the output register is free, behind the
// frame memory's registered read; an exit on an empty stack gives a single record. A request
// is first latched into the item registers, then its first record into the output register.
// Synchronous reset empties the stack and the output register; the frame memory is not cleared.
module call_trace_shadow_stack_unit
   import ctss_pkg::*;
#(
   parameter int STACK_DEPTH = StackDepth
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_opcode,
   input  logic [WordWidth-1:0] req_stack_pointer,
   input  logic [WordWidth-1:0] req_return_address,
   input  logic [WordWidth-1:0] req_callee,
   input  logic [WordWidth-1:0] req_timestamp,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [WordWidth-1:0] rsp_record_callee,
   output logic [WordWidth-1:0] rsp_record_time,
   output logic [WordWidth-1:0] rsp_resume_address,
   output logic                 rsp_last,
   output logic [1:0]           rsp_status
);

   localparam int AddrWidth  = $clog2(STACK_DEPTH);
   localparam int LevelWidth = $clog2(STACK_DEPTH + 1);
   localparam int CountWidth = $clog2(MaxResults);
   localparam int FrameWidth = 2 * WordWidth;

   typedef enum logic [1:0] {
      S_IDLE,
      S_ENTER,
      S_TAIL,
      S_POP
   } state_type;

   state_type             state_ff, state_in;
   logic [LevelWidth-1:0] level_ff, level_in;
   logic [WordWidth-1:0]  top_sp_ff, top_sp_in;
   logic [WordWidth-1:0]  top_ret_ff, top_ret_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [WordWidth-1:0]  resume_ff, resume_in;
   logic [WordWidth-1:0]  item_sp_ff, item_sp_in;
   logic [WordWidth-1:0]  item_ret_ff, item_ret_in;
   logic [WordWidth-1:0]  item_callee_ff, item_callee_in;
   logic [WordWidth-1:0]  item_time_ff, item_time_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WordWidth-1:0]  rsp_callee_ff, rsp_callee_in;
   logic [WordWidth-1:0]  rsp_time_ff, rsp_time_in;
   logic [WordWidth-1:0]  rsp_resume_ff, rsp_resume_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic [1:0]            rsp_status_ff, rsp_status_in;

   logic                  out_free;
   logic                  wr_en;
   logic [AddrWidth-1:0]  wr_addr;
   logic [FrameWidth-1:0] wr_data;
   logic [AddrWidth-1:0]  rd_addr;
   logic [FrameWidth-1:0] rd_data;
   logic [LevelWidth-1:0] level_m1;
   logic [LevelWidth-1:0] level_m2;
   logic [LevelWidth-1:0] level_m3;
   logic [WordWidth-1:0]  rd_sp;
   logic [WordWidth-1:0]  rd_ret;
   logic                  more;

   ctss_ram #(
      .Width(FrameWidth),
      .Depth(STACK_DEPTH)
   ) u_frames (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign level_m1  = level_ff - LevelWidth'(1);
   assign level_m2  = level_ff - LevelWidth'(2);
   assign level_m3  = level_ff - LevelWidth'(3);
   assign rd_sp     = rd_data[FrameWidth-1:WordWidth];
   assign rd_ret    = rd_data[WordWidth-1:0];
   assign more      = (level_m1 != '0) && (rd_sp <= item_sp_ff)
                      && (count_ff != CountWidth'(MaxResults - 1));
   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in       = state_ff;
      level_in       = level_ff;
      top_sp_in      = top_sp_ff;
      top_ret_in     = top_ret_ff;
      count_in       = count_ff;
      resume_in      = resume_ff;
      item_sp_in     = item_sp_ff;
      item_ret_in    = item_ret_ff;
      item_callee_in = item_callee_ff;
      item_time_in   = item_time_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_callee_in  = rsp_callee_ff;
      rsp_time_in    = rsp_time_ff;
      rsp_resume_in  = rsp_resume_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_status_in  = rsp_status_ff;
      wr_en          = 1'b0;
      wr_addr        = level_ff[AddrWidth-1:0];
      wr_data        = {item_sp_ff, item_ret_ff};
      rd_addr        = level_m2[AddrWidth-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               item_sp_in     = req_stack_pointer;
               item_ret_in    = req_return_address;
               item_callee_in = req_callee;
               item_time_in   = req_timestamp;
               count_in       = '0;
               resume_in      = top_ret_ff;
               state_in       = (req_opcode == OpExit) ? S_POP : S_ENTER;
            end
         end
         S_ENTER: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_time_in   = item_time_ff;
               rsp_resume_in = '0;
               rsp_status_in = StatusOk;
               if ((level_ff != '0) && (top_sp_ff == item_sp_ff)) begin
                  rsp_callee_in = '0;
                  rsp_last_in   = 1'b0;
                  state_in      = S_TAIL;
               end else begin
                  rsp_callee_in = item_callee_ff;
                  rsp_last_in   = 1'b1;
                  state_in      = S_IDLE;
                  if (level_ff < LevelWidth'(STACK_DEPTH)) begin
                     wr_en      = 1'b1;
                     top_sp_in  = item_sp_ff;
                     top_ret_in = item_ret_ff;
                     level_in   = level_ff + LevelWidth'(1);
                  end else begin
                     rsp_status_in = StatusFull;
                  end
               end
            end
         end
         S_TAIL: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_callee_in = item_callee_ff;
               rsp_time_in   = item_time_ff;
               rsp_resume_in = '0;
               rsp_last_in   = 1'b1;
               rsp_status_in = StatusOk;
               state_in      = S_IDLE;
            end
         end
         S_POP: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_callee_in = '0;
               rsp_time_in   = item_time_ff;
               if (level_ff == '0) begin
                  rsp_resume_in = '0;
                  rsp_last_in   = 1'b1;
                  rsp_status_in = StatusEmpty;
                  state_in      = S_IDLE;
               end else begin
                  level_in      = level_m1;
                  rsp_status_in = StatusOk;
                  rsp_last_in   = !more;
                  rsp_resume_in = more ? '0 : resume_ff;
                  if (level_m1 != '0) begin
                     top_sp_in  = rd_sp;
                     top_ret_in = rd_ret;
                  end
                  if (more) begin
                     rd_addr  = level_m3[AddrWidth-1:0];
                     count_in = count_ff + CountWidth'(1);
                  end else begin
                     state_in = S_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_sp_ff      <= top_sp_in;
      top_ret_ff     <= top_ret_in;
      count_ff       <= count_in;
      resume_ff      <= resume_in;
      item_sp_ff     <= item_sp_in;
      item_ret_ff    <= item_ret_in;
      item_callee_ff <= item_callee_in;
      item_time_ff   <= item_time_in;
      rsp_callee_ff  <= rsp_callee_in;
      rsp_time_ff    <= rsp_time_in;
      rsp_resume_ff  <= rsp_resume_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_status_ff  <= rsp_status_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_record_callee  = rsp_callee_ff;
   assign rsp_record_time    = rsp_time_ff;
   assign rsp_resume_address = rsp_resume_ff;
   assign rsp_last           = rsp_last_ff;
   assign rsp_status         = rsp_status_ff;

`ifndef ASSERT_OFF
   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      level_ff <= LevelWidth'(STACK_DEPTH))
      else $error("Stack level exceeds the stack depth.");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      wr_en |=> (level_ff == $past(level_ff) + LevelWidth'(1)))
      else $error("A push did not raise the stack level by one.");

   a_write_only_on_enter: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_ENTER) && (level_ff < LevelWidth'(STACK_DEPTH)))
      else $error("Frame memory written outside a legal push.");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == StatusEmpty)) |-> rsp_last)
      else $error("An empty-stack exit record is not the final record.");

   a_resume_on_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_resume_address == '0))
      else $error("Resume address present on a record that is not final.");
`endif

endmodule

### sv/ctss_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module ctss_ram #(
   parameter int Width = 8,
   parameter int Depth = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
